/* rtl/mwm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwm_pkg
// shared widths and the item type passed from the mixing front end to the
// normalizing back end
// ----------------------------------------------------------------------------
package mwm_pkg;

    // command and wheel value width on the ports
    localparam int CMD_W = 16;
    // signed width of a sum of three 16 bit commands
    localparam int SUM_W = CMD_W + 2;
    // magnitude width of such a sum
    localparam int MAG_W = CMD_W + 1;
    // number of wheels
    localparam int NUM_WHEELS = 4;
    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // wheel indexes
    localparam int WHEEL_FL = 0;
    localparam int WHEEL_FR = 1;
    localparam int WHEEL_BL = 2;
    localparam int WHEEL_BR = 3;

    typedef struct packed {
        logic [NUM_WHEELS-1:0][MAG_W-1:0] mag;   // wheel target magnitudes
        logic [NUM_WHEELS-1:0]            neg;   // wheel target signs
        logic [NUM_WHEELS-1:0][CMD_W-1:0] raw;   // unscaled targets, low bits
        logic [MAG_W-1:0]                 peak;  // largest magnitude
        logic                             scale; // peak exceeds one
    } t_mix_item;

endpackage

/* rtl/mecanum_wheel_mixer_top.sv */
`timescale 1ns / 1ps
// path: front end register, queue, divider stages, output register, in that order
// throughput: one item per cycle while the wheel side does not stall; the divider is
//   pipelined in FRAC_BITS + 1 stages, one quotient bit per stage for all four wheels
// reset: i_rst_n synchronous active low, clears all valid flags and the queue
// ----------------------------------------------------------------------------
// mecanum_wheel_mixer_top
// mecanum drive inverse kinematics: clamps forward, strafe and rotate
// commands, mixes them into four wheel targets and scales them down by the
// peak magnitude when it exceeds one
// ----------------------------------------------------------------------------
module mecanum_wheel_mixer_top
    import mwm_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // forward_cmd[15:0], strafe_cmd[31:16],
                                       // rotate_cmd[47:32]
    // wheel stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata   // front_left_out[15:0], front_right_out[31:16],
                                       // back_left_out[47:32], back_right_out[63:48]
);

    // front end to queue
    logic                             w_f_valid;
    logic                             w_f_ready;
    t_mix_item                        w_f_item;
    // queue to back end
    logic                             w_q_valid;
    logic                             w_q_ready;
    t_mix_item                        w_q_item;
    // back end result
    logic [NUM_WHEELS-1:0][CMD_W-1:0] w_wheel;

    // clamp, mix and peak search in one registered stage
    mwm_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_forward_cmd (s_axis_tdata[15:0]),
        .i_strafe_cmd  (s_axis_tdata[31:16]),
        .i_rotate_cmd  (s_axis_tdata[47:32]),
        .o_valid       (w_f_valid),
        .i_ready       (w_f_ready),
        .o_item        (w_f_item)
    );

    // short queue so front and back stall on their own
    mwm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_item  (w_f_item),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_item  (w_q_item)
    );

    // divider pipeline and output register
    mwm_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .o_ready (w_q_ready),
        .i_item  (w_q_item),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_wheel (w_wheel)
    );

    // wheel order on the bus: front-left lowest
    assign m_axis_tdata = {w_wheel[WHEEL_BR], w_wheel[WHEEL_BL],
                           w_wheel[WHEEL_FR], w_wheel[WHEEL_FL]};

endmodule

/* rtl/mwm_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwm_front
// clamps the commands, forms the four wheel targets, finds the peak
// magnitude and flags whether the targets need scaling
// ----------------------------------------------------------------------------
module mwm_front
    import mwm_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [CMD_W-1:0] i_forward_cmd,
    input  logic signed [CMD_W-1:0] i_strafe_cmd,
    input  logic signed [CMD_W-1:0] i_rotate_cmd,
    output logic                    o_valid,
    input  logic                    i_ready,
    output t_mix_item               o_item
);

    // clamp limit: one, or out of reach of a 16 bit command
    localparam logic signed [SUM_W-1:0] CLAMP_LIM = (FRAC_BITS >= CMD_W - 1)
        ? SUM_W'(1 << (CMD_W - 1)) : SUM_W'(1 << FRAC_BITS);
    // peak threshold: one, or beyond any reachable magnitude
    localparam logic [MAG_W-1:0] PEAK_LIM = (FRAC_BITS >= MAG_W)
        ? {MAG_W{1'b1}} : MAG_W'(1 << FRAC_BITS);

    logic                                     r_vld;
    t_mix_item                                r_item;
    t_mix_item                                n_item;
    logic signed [SUM_W-1:0]                  c_fwd;
    logic signed [SUM_W-1:0]                  c_side;
    logic signed [SUM_W-1:0]                  c_turn;
    logic signed [NUM_WHEELS-1:0][SUM_W-1:0]  c_wheel;
    logic [MAG_W-1:0]                         c_peak;

    function automatic logic signed [SUM_W-1:0] clamp_cmd(
        input logic signed [CMD_W-1:0] v
    );
        logic signed [SUM_W-1:0] x;
        x = SUM_W'(v);
        if (x > CLAMP_LIM) begin
            return CLAMP_LIM;
        end else if (x < -CLAMP_LIM) begin
            return -CLAMP_LIM;
        end
        return x;
    endfunction

    always_comb begin
        c_fwd  = clamp_cmd(i_forward_cmd);
        c_side = -clamp_cmd(i_strafe_cmd);
        c_turn = clamp_cmd(i_rotate_cmd);

        c_wheel[WHEEL_FL] = c_fwd + c_side - c_turn;
        c_wheel[WHEEL_FR] = c_fwd - c_side + c_turn;
        c_wheel[WHEEL_BL] = c_fwd - c_side - c_turn;
        c_wheel[WHEEL_BR] = c_fwd + c_side + c_turn;

        c_peak = '0;
        for (int k = 0; k < NUM_WHEELS; k++) begin
            n_item.neg[k] = c_wheel[k][SUM_W-1];
            n_item.mag[k] = n_item.neg[k] ? MAG_W'(-c_wheel[k]) : MAG_W'(c_wheel[k]);
            n_item.raw[k] = c_wheel[k][CMD_W-1:0];
            if (n_item.mag[k] > c_peak) begin
                c_peak = n_item.mag[k];
            end
        end
        n_item.peak  = c_peak;
        n_item.scale = (c_peak > PEAK_LIM);
    end

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

/* rtl/mwm_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwm_fifo
// short queue of mixed items between the front and back ends
// ----------------------------------------------------------------------------
module mwm_fifo
    import mwm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_mix_item i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_mix_item o_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_mix_item        r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             c_push;
    logic             c_pop;

    assign o_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign c_push  = i_valid && o_ready;
    assign c_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (c_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (c_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (c_push && !c_pop) begin
                r_count <= r_count + 1'b1;
            end else if (c_pop && !c_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (c_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

/* rtl/mwm_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwm_back
// pipelined restoring divider, one quotient bit per stage for all four
// wheels, then sign restore (raw targets if unscaled) and the output register
// ----------------------------------------------------------------------------
module mwm_back
    import mwm_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  t_mix_item                        i_item,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [NUM_WHEELS-1:0][CMD_W-1:0] o_wheel
);

    localparam int NSTG  = FRAC_BITS + 1;
    localparam int QW    = FRAC_BITS + 1;
    localparam int REM_W = MAG_W + 1;
    localparam int QX_W  = (QW > CMD_W) ? QW : CMD_W;

    logic                                  c_en;
    logic                                  r_vld   [NSTG];
    logic [NUM_WHEELS-1:0][REM_W-1:0]      r_rem   [NSTG];
    logic [NUM_WHEELS-1:0][QW-1:0]         r_q     [NSTG];
    logic [NUM_WHEELS-1:0]                 r_neg   [NSTG];
    logic [NUM_WHEELS-1:0][CMD_W-1:0]      r_raw   [NSTG];
    logic [MAG_W-1:0]                      r_peak  [NSTG];
    logic                                  r_scale [NSTG];
    logic                                  r_ovld;
    logic [NUM_WHEELS-1:0][CMD_W-1:0]      r_owheel;
    logic [NUM_WHEELS-1:0][CMD_W-1:0]      n_owheel;

    // whole pipe moves together unless the output is stuck
    assign c_en    = !r_ovld || i_ready;
    assign o_ready = c_en;
    assign o_valid = r_ovld;
    assign o_wheel = r_owheel;

    for (genvar s = 0; s < NSTG; s++) begin : g_stg
        logic                             w_vin;
        logic [NUM_WHEELS-1:0]            w_neg;
        logic [NUM_WHEELS-1:0][CMD_W-1:0] w_raw;
        logic [MAG_W-1:0]                 w_peak;
        logic                             w_scale;
        logic [NUM_WHEELS-1:0][REM_W-1:0] w_cand;
        logic [NUM_WHEELS-1:0][QW-1:0]    w_qprev;
        logic [NUM_WHEELS-1:0][REM_W-1:0] n_rem;
        logic [NUM_WHEELS-1:0][QW-1:0]    n_q;
        logic                             w_ge;

        if (s == 0) begin : g_first
            always_comb begin
                w_vin   = i_valid;
                w_neg   = i_item.neg;
                w_raw   = i_item.raw;
                w_peak  = i_item.peak;
                w_scale = i_item.scale;
                for (int l = 0; l < NUM_WHEELS; l++) begin
                    w_cand[l]  = REM_W'(i_item.mag[l]);
                    w_qprev[l] = '0;
                end
            end
        end else begin : g_next
            always_comb begin
                w_vin   = r_vld[s-1];
                w_neg   = r_neg[s-1];
                w_raw   = r_raw[s-1];
                w_peak  = r_peak[s-1];
                w_scale = r_scale[s-1];
                for (int l = 0; l < NUM_WHEELS; l++) begin
                    w_cand[l]  = {r_rem[s-1][l][REM_W-2:0], 1'b0};
                    w_qprev[l] = r_q[s-1][l];
                end
            end
        end

        // one quotient bit per wheel
        always_comb begin
            w_ge = 1'b0;
            for (int l = 0; l < NUM_WHEELS; l++) begin
                w_ge     = (w_cand[l] >= REM_W'(w_peak));
                n_rem[l] = w_ge ? (w_cand[l] - REM_W'(w_peak)) : w_cand[l];
                n_q[l]   = {w_qprev[l][QW-2:0], w_ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (c_en) begin
                r_vld[s] <= w_vin;
            end
            if (c_en) begin
                r_rem[s]   <= n_rem;
                r_q[s]     <= n_q;
                r_neg[s]   <= w_neg;
                r_raw[s]   <= w_raw;
                r_peak[s]  <= w_peak;
                r_scale[s] <= w_scale;
            end
        end
    end

    // restore sign, truncation toward zero falls out of the magnitude divide
    always_comb begin
        logic [QX_W-1:0]  q_ext;
        logic [CMD_W-1:0] q16;
        for (int l = 0; l < NUM_WHEELS; l++) begin
            q_ext = QX_W'(r_q[NSTG-1][l]);
            q16   = q_ext[CMD_W-1:0];
            if (r_scale[NSTG-1]) begin
                n_owheel[l] = r_neg[NSTG-1][l] ? (-q16) : q16;
            end else begin
                n_owheel[l] = r_raw[NSTG-1][l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (c_en) begin
            r_ovld <= r_vld[NSTG-1];
        end
        if (c_en) begin
            r_owheel <= n_owheel;
        end
    end

endmodule

/* bench/mecanum_wheel_mixer_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mecanum_wheel_mixer_top_tb
// self-checking bench for the mecanum wheel mixer: drives forward, strafe and
// rotate command items, predicts the four clamped, mixed and peak-normalized
// wheel values in the bench and compares every wheel item field by field,
// with random gaps on the command side and random stalls on the wheel side
// ----------------------------------------------------------------------------
module mecanum_wheel_mixer_top_tb;
    import mwm_pkg::*;

    localparam int FRAC_BITS      = 14;
    localparam int LATENCY        = FRAC_BITS + 3;
    // cycles without any accepted item before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;

    // four wheel values, indexed by the package wheel indexes
    typedef logic [NUM_WHEELS-1:0][CMD_W-1:0] t_wheel_set;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;  // forward_cmd[15:0], strafe_cmd[31:16],
                                      // rotate_cmd[47:32]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;        // front_left_out[15:0], front_right_out[31:16],
                                      // back_left_out[47:32], back_right_out[63:48]

    // wheel sets still owed by the block, oldest first
    t_wheel_set pending_wheels [$];
    t_wheel_set owed_wheels;
    int         fail_count  = 0;
    int         idle_cycles = 0;
    int         stall_left  = 0;
    bit         gaps_on     = 1'b0;
    bit         stalls_on   = 1'b0;
    string      wheel_label [NUM_WHEELS] =
        '{"front_left_out", "front_right_out", "back_left_out", "back_right_out"};

    mecanum_wheel_mixer_top #(
        .FRAC_BITS(FRAC_BITS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    // saturate one command to plus or minus one
    function automatic longint clamp_cmd(input logic [CMD_W-1:0] raw, input longint unit);
        longint v;
        v = longint'($signed(raw));
        if (v > unit) begin
            return unit;
        end
        if (v < -unit) begin
            return -unit;
        end
        return v;
    endfunction

    // inverse kinematics: mix, then scale everything down by the peak if above one
    function automatic t_wheel_set mix_wheels(input logic [CMD_W-1:0] fwd_raw,
                                              input logic [CMD_W-1:0] strafe_raw,
                                              input logic [CMD_W-1:0] rot_raw);
        longint     unit, fwd, side, turn, peak, mag;
        longint     tgt [NUM_WHEELS];
        t_wheel_set res;
        unit = longint'(1) <<< FRAC_BITS;
        fwd  = clamp_cmd(fwd_raw, unit);
        side = -clamp_cmd(strafe_raw, unit);
        turn = clamp_cmd(rot_raw, unit);
        tgt[WHEEL_FL] = fwd + side - turn;
        tgt[WHEEL_FR] = fwd - side + turn;
        tgt[WHEEL_BL] = fwd - side - turn;
        tgt[WHEEL_BR] = fwd + side + turn;
        peak = 0;
        for (int k = 0; k < NUM_WHEELS; k++) begin
            mag = (tgt[k] < 0) ? -tgt[k] : tgt[k];
            if (mag > peak) begin
                peak = mag;
            end
        end
        for (int k = 0; k < NUM_WHEELS; k++) begin
            // strictly greater: a peak of exactly one passes unscaled
            if (peak > unit) begin
                tgt[k] = (tgt[k] * unit) / peak;  // truncates toward zero
            end
            res[k] = 16'(tgt[k]);
        end
        return res;
    endfunction

    // sender gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // command biased toward the interesting region around plus or minus one
    function automatic logic [CMD_W-1:0] pick_cmd();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            case ($urandom_range(0, 6))
                0:       return 16'h8000;
                1:       return 16'h7fff;
                2:       return 16'(16384);
                3:       return 16'(-16384);
                4:       return 16'(16385);
                5:       return 16'(-16385);
                default: return 16'h0000;
            endcase
        end
        if (r < 3) begin
            return 16'($urandom());
        end
        return 16'($urandom_range(0, 32768) - 16384);
    endfunction

    // send one command item; valid stays high when the next item follows directly
    task automatic send_cmd(input logic [CMD_W-1:0] fwd, input logic [CMD_W-1:0] strafe,
                            input logic [CMD_W-1:0] rot);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rot, strafe, fwd};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_wheels.push_back(mix_wheels(fwd, strafe, rot));
    endtask

    task automatic go_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_wheels.size() != 0) @(posedge i_clk);
    endtask

    // extremes of each command, clamping, and the scale/no-scale boundary
    task automatic test_directed();
        gaps_on   <= 1'b0;
        stalls_on <= 1'b0;
        send_cmd(16'(0), 16'(0), 16'(0));               // all zero, no division
        send_cmd(16'(16384), 16'(0), 16'(0));
        send_cmd(16'(-16384), 16'(0), 16'(0));
        send_cmd(16'(0), 16'(16384), 16'(0));
        send_cmd(16'(0), 16'(-16384), 16'(0));
        send_cmd(16'(0), 16'(0), 16'(16384));
        send_cmd(16'(0), 16'(0), 16'(-16384));
        send_cmd(16'h8000, 16'(0), 16'(0));             // most negative saturates
        send_cmd(16'(0), 16'h8000, 16'(0));
        send_cmd(16'(0), 16'(0), 16'h8000);
        send_cmd(16'h7fff, 16'(0), 16'(0));
        send_cmd(16'(0), 16'h7fff, 16'(0));
        send_cmd(16'(0), 16'(0), 16'h7fff);
        send_cmd(16'(16385), 16'(-16385), 16'(16385));  // just past the clamp
        send_cmd(16'(16384), 16'(16384), 16'(16384));   // peak three, scaled
        send_cmd(16'(16384), 16'(16384), 16'(-16384));
        send_cmd(16'h8000, 16'h8000, 16'h8000);
        send_cmd(16'h7fff, 16'h8000, 16'h7fff);
        send_cmd(16'(8192), 16'(8192), 16'(0));         // peak exactly one
        send_cmd(16'(8193), 16'(8192), 16'(0));         // peak one lsb over one
        send_cmd(16'(-5000), 16'(12000), 16'(7000));    // truncation of negatives
        send_cmd(16'(5000), 16'(-12001), 16'(-7003));
        go_idle();
    endtask

    // biased random commands with gaps and stalls on both sides
    task automatic test_random_biased(input int count);
        gaps_on   <= 1'b1;
        stalls_on <= 1'b1;
        for (int n = 0; n < count; n++) begin
            send_cmd(pick_cmd(), pick_cmd(), pick_cmd());
        end
        go_idle();
    endtask

    // full 16 bit range on every command
    task automatic test_random_full(input int count);
        gaps_on   <= 1'b1;
        stalls_on <= 1'b1;
        for (int n = 0; n < count; n++) begin
            send_cmd(16'($urandom()), 16'($urandom()), 16'($urandom()));
        end
        go_idle();
    endtask

    // back to back items with no new stalls started on the wheel side
    task automatic test_back_to_back(input int count);
        gaps_on   <= 1'b0;
        stalls_on <= 1'b0;
        for (int n = 0; n < count; n++) begin
            send_cmd(pick_cmd(), pick_cmd(), pick_cmd());
        end
        go_idle();
    endtask

    // bursts separated by full drains of the pipeline
    task automatic test_drain_pause(input int bursts);
        for (int b = 0; b < bursts; b++) begin
            gaps_on   <= 1'b0;
            stalls_on <= 1'b1;
            repeat ($urandom_range(1, 25)) begin
                send_cmd(pick_cmd(), pick_cmd(), pick_cmd());
            end
            go_idle();
            wait_drained();
        end
    endtask

    // wheel side: runs of ready broken by stalls, mostly short, a few long
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 99) < 25) begin
            m_axis_tready <= 1'b0;
            stall_left    <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                         : $urandom_range(0, 2);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // compare every accepted wheel item with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_wheels.size() == 0) begin
                $error("unexpected wheel item %h", m_axis_tdata);
                fail_count++;
            end else begin
                owed_wheels = pending_wheels.pop_front();
                for (int k = 0; k < NUM_WHEELS; k++) begin
                    if (m_axis_tdata[k*CMD_W +: CMD_W] !== owed_wheels[k]) begin
                        $error("%s expected %0d actual %0d", wheel_label[k],
                               $signed(owed_wheels[k]),
                               $signed(m_axis_tdata[k*CMD_W +: CMD_W]));
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog: too long with no item moving on either side means a hang
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("mecanum_wheel_mixer_top_tb failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        // synchronous reset held low from time zero, released on a clock edge
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_biased(850);
        test_drain_pause(12);
        test_random_full(500);
        test_back_to_back(300);

        wait_drained();
        repeat (2 * LATENCY) @(posedge i_clk);
        if (fail_count == 0 && pending_wheels.size() == 0) begin
            $display("mecanum_wheel_mixer_top_tb passed");
        end else begin
            $display("mecanum_wheel_mixer_top_tb failed");
        end
        $finish;
    end

endmodule
